/* rtl/tdpt_pkg.sv */
// Package for the trial-division prime test core.
// Holds the divider handshake structs and fixed constants; no dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

    // First odd trial divisor and the step between divisors
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;
    // Smallest even prime
    localparam int EVEN_PRIME    = 2;

    // Control from the sequencer to the serial divider
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // Status from the serial divider back to the sequencer
    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

/* rtl/tdpt_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdpt_pkg for the control and status structs.
`timescale 1ns / 1ps

module tdpt_divider #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdpt_pkg::t_div_ctrl   i_ctrl,
    input  logic [W-1:0]          i_dividend,
    input  logic [W-1:0]          i_divisor,
    output tdpt_pkg::t_div_stat   o_stat,
    output logic [W-1:0]          o_quotient,
    output logic [W-1:0]          o_remainder
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  r_dvd, n_dvd;
    logic [W-1:0]  r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [W:0]    trial;
    logic [W:0]    diff;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {r_rem, r_dvd[W-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            // Load a new request
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Advance one quotient bit; restore when the subtract goes negative
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
                n_dvd = {r_dvd[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_dvd = {r_dvd[W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_stat.done  = r_done;
    assign o_quotient   = r_dvd;
    assign o_remainder  = r_rem;

endmodule

/* rtl/trial_division_prime_test_core.sv */
// Trial-division prime test: screens sign, small and even values at once,
// then walks odd divisors d while d <= value / d, one serial division per
// divisor tried. One request at a time; busy stays high during a divisor walk
// and drops as the one-cycle o_valid strobe rises; the receiver cannot stall,
// so the next request may start on the edge that takes the result.
// Synchronous active-low reset returns to idle.
`timescale 1ns / 1ps

module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          busy,
    output logic                          o_valid,
    output logic                          o_is_prime
);

    localparam int W = VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state       r_state, n_state;
    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_d, n_d;
    logic         r_div_start, n_div_start;
    logic         r_valid, n_valid;
    logic         r_prime, n_prime;

    tdpt_pkg::t_div_ctrl div_ctrl;
    tdpt_pkg::t_div_stat div_stat;
    logic [W-1:0]        div_q;
    logic [W-1:0]        div_r;

    logic [W-1:0] in_bits;
    logic         in_neg;
    logic         in_le1;
    logic         in_even;
    logic         in_two;

    // Screen the incoming request
    assign in_bits = i_value;
    assign in_neg  = in_bits[W-1];
    assign in_le1  = (in_bits[W-1:1] == '0);
    assign in_even = !in_bits[0];
    assign in_two  = (in_bits == W'(tdpt_pkg::EVEN_PRIME));

    assign div_ctrl.start = r_div_start;

    tdpt_divider #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (div_ctrl),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_stat      (div_stat),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Sequence the divisor walk
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_div_start = 1'b0;
        n_valid     = 1'b0;
        n_prime     = r_prime;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n = in_bits;
                    if (in_neg || in_le1) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                    end else if (in_even) begin
                        n_valid = 1'b1;
                        n_prime = in_two;
                    end else begin
                        n_d         = W'(tdpt_pkg::FIRST_DIVISOR);
                        n_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (r_d > div_q) begin
                        // Divisor passed the square root: no factor found
                        n_valid = 1'b1;
                        n_prime = 1'b1;
                        n_state = S_IDLE;
                    end else if (div_r == '0) begin
                        // Exact factor: composite
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        // Advance to the next odd divisor
                        n_d         = r_d + W'(tdpt_pkg::DIVISOR_STEP);
                        n_div_start = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_valid     <= n_valid;
        end
    end

    // Hold operands and the result bit
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_d     <= n_d;
        r_prime <= n_prime;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for trial_division_prime_test_core.
// Depends on rtl/tdpt_pkg.sv and rtl/trial_division_prime_test_core.sv; reads no files.
`timescale 1ns / 1ps

module tb_top;

    localparam int VALUE_WIDTH  = 32;
    // Longest correct wait is the largest 31-bit prime: about 23170 odd divisors,
    // each one a full serial division, so allow several times that
    localparam int IDLE_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES = 40;

    // Scoreboard: predicts the primality verdict of each request and checks strobes
    class prime_verdict_board;
        logic [VALUE_WIDTH-1:0] tested_values[$];
        bit                     expected_verdicts[$];
        int unsigned            mismatches;

        function bit predict_prime(logic [VALUE_WIDTH-1:0] raw);
            longint unsigned n;
            longint unsigned d;
            n = raw;
            // Negative, zero and one are never prime
            if (raw[VALUE_WIDTH-1]) return 1'b0;
            if (n <= 1) return 1'b0;
            // Even values: only the even prime passes
            if (!n[0]) return (n == tdpt_pkg::EVEN_PRIME);
            // Walk odd divisors while d * d <= n
            for (d = tdpt_pkg::FIRST_DIVISOR; d <= n / d; d += tdpt_pkg::DIVISOR_STEP) begin
                if (n % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(logic [VALUE_WIDTH-1:0] v);
            tested_values     = {tested_values, v};
            expected_verdicts = {expected_verdicts, predict_prime(v)};
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_verdict(bit got);
            logic [VALUE_WIDTH-1:0] v;
            bit                     want;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result is_prime=%0b", got));
                return;
            end
            v    = tested_values.pop_front();
            want = expected_verdicts.pop_front();
            if (got !== want)
                report_mismatch($sformatf("value %0d: is_prime=%0b, want %0b",
                                          $signed(v), got, want));
        endtask

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic                          busy;
    logic                          o_valid;
    logic                          o_is_prime;

    prime_verdict_board verdicts = new();
    int unsigned        idle_pct = 0;
    int unsigned        quiet_cycles = 0;

    trial_division_prime_test_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_value    (i_value),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Observe requests and results on pre-edge values; hang watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                verdicts.check_verdict(o_is_prime);
            if (start && !busy)
                verdicts.note_request(i_value);
            if (o_valid || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Issue one request, with an optional random gap, and hold it until taken
    task send_request(input logic [VALUE_WIDTH-1:0] v);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and hold off until every outstanding verdict is back
    task wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (verdicts.pending() != 0);
    endtask

    // Mostly small values so each test stays short; large ones exit early
    function logic [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] v;
        int unsigned            pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            v = $urandom_range(16383);
        end else if (pick < 65) begin
            // odd squares and products of small odd numbers
            v = ($urandom_range(60) * 2 + 3) * ($urandom_range(60) * 2 + 3);
        end else if (pick < 80) begin
            // full-width even or negative: screened at once
            v = $urandom;
            if ($urandom_range(1)) v[0] = 1'b0;
            else v[VALUE_WIDTH-1] = 1'b1;
        end else begin
            // large odd multiple of three
            v = 3 * ($urandom_range(715827882) | 1);
        end
        return v;
    endfunction

    logic [VALUE_WIDTH-1:0] directed_values[21] = '{
        32'h8000_0000,   // most negative
        32'hFFFF_FFFF,   // minus one
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7,
        32'd9,           // square of first divisor
        32'd25, 32'd49,  // divisor squared equals value
        32'd63001,       // 251 squared
        32'd65521,       // largest 16-bit prime
        32'd65535,
        32'h7FFF_FFFE,   // largest even
        32'h7FFF_FFFD,   // divisible by five
        32'h7FFF_FFFF,   // largest positive, prime: full divisor walk
        32'hAAAA_AAAB,   // negative odd
        32'd2147483629,  // large prime below the top
        32'd1000003
    };

    int unsigned phase_idle[4] = '{0, 59, 0, 36};

    initial begin
        // Hold reset, then release it before the first request
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, no gaps
        foreach (directed_values[i])
            send_request(directed_values[i]);
        wait_for_drain();

        // Random phases with varying sender gaps
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            repeat (20) send_request(random_value());
            wait_for_drain();
        end

        // Let any stray strobe show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdicts.mismatches == 0 && verdicts.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/tdpt_pkg.sv
rtl/tdpt_divider.sv
rtl/trial_division_prime_test_core.sv
sim/tb_top.sv
